### rtl/core/nmea_sentence_field_extractor_defines.svh
// ---------------------------------------------------------------------------
// NMEA field extractor assertion macros
// Property check wrappers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH
// checked property, masked while reset is high
`define NSFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, live through reset
`define NSFE_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSFE_ASSERT(lbl, clk, rst, prop, msg)
`define NSFE_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/nsfe_pkg.sv
// ---------------------------------------------------------------------------
// NMEA field extractor package
// Shared widths, character codes, field ids and field decode.
// ---------------------------------------------------------------------------
package nsfe_pkg;

  localparam int HEADER_LEN = 5;
  localparam int HDR_IDX_W  = $clog2(HEADER_LEN);
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TALKER_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TALKER_SECOND = 1'd1;

  localparam logic [7:0] TALKER_FIRST_RST  = 8'd71; // 'G'
  localparam logic [7:0] TALKER_SECOND_RST = 8'd78; // 'N'

  // characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  // completion bits
  localparam logic [2:0] DONE_GGA = 3'h1;
  localparam logic [2:0] DONE_GSV = 3'h2;
  localparam logic [2:0] DONE_RMC = 3'h4;

  // field ids
  localparam logic [3:0] FLD_LAT    = 4'd0;
  localparam logic [3:0] FLD_LATDIR = 4'd1;
  localparam logic [3:0] FLD_LON    = 4'd2;
  localparam logic [3:0] FLD_LONDIR = 4'd3;
  localparam logic [3:0] FLD_FIX    = 4'd4;
  localparam logic [3:0] FLD_USED   = 4'd5;
  localparam logic [3:0] FLD_ALT    = 4'd6;
  localparam logic [3:0] FLD_TOTAL  = 4'd7;
  localparam logic [3:0] FLD_TIME   = 4'd8;
  localparam logic [3:0] FLD_SPEED  = 4'd9;
  localparam logic [3:0] FLD_COURSE = 4'd10;
  localparam logic [3:0] FLD_DATE   = 4'd11;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_HDR  = 3'b010,
    MODE_DATA = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GGA  = 2'd1,
    KIND_GSV  = 2'd2,
    KIND_RMC  = 2'd3
  } kind_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
    logic [3:0] limit;
  } field_t;

  function automatic field_t field_lookup(kind_t kind, logic [7:0] comma);
    field_t f;
    f = '{hit: 1'b0, id: 4'd0, limit: 4'd0};
    case (kind)
      KIND_GGA: begin
        case (comma)
          8'd2:    f = '{1'b1, FLD_LAT,    4'd9};
          8'd3:    f = '{1'b1, FLD_LATDIR, 4'd1};
          8'd4:    f = '{1'b1, FLD_LON,    4'd10};
          8'd5:    f = '{1'b1, FLD_LONDIR, 4'd1};
          8'd6:    f = '{1'b1, FLD_FIX,    4'd1};
          8'd7:    f = '{1'b1, FLD_USED,   4'd2};
          8'd9:    f = '{1'b1, FLD_ALT,    4'd6};
          default: f = '{1'b0, 4'd0, 4'd0};
        endcase
      end
      KIND_GSV: begin
        if (comma == 8'd3) f = '{1'b1, FLD_TOTAL, 4'd2};
      end
      KIND_RMC: begin
        case (comma)
          8'd1:    f = '{1'b1, FLD_TIME,   4'd6};
          8'd4:    f = '{1'b1, FLD_LATDIR, 4'd1};
          8'd6:    f = '{1'b1, FLD_LONDIR, 4'd1};
          8'd7:    f = '{1'b1, FLD_SPEED,  4'd5};
          8'd8:    f = '{1'b1, FLD_COURSE, 4'd5};
          8'd9:    f = '{1'b1, FLD_DATE,   4'd6};
          default: f = '{1'b0, 4'd0, 4'd0};
        endcase
      end
      default: f = '{1'b0, 4'd0, 4'd0};
    endcase
    return f;
  endfunction

endpackage

### rtl/core/nsfe_if.sv
// ---------------------------------------------------------------------------
// NMEA field extractor channels
// Byte input, result output and register write channels.
// ---------------------------------------------------------------------------
interface nsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfe_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [3:0] field_id;
  logic [3:0] char_pos;
  logic [7:0] char_value;
  logic       sentence_start;
  logic [2:0] complete_mask;
  logic [7:0] lock_value;

  modport source (output valid, output write_valid, output field_id, output char_pos,
                  output char_value, output sentence_start, output complete_mask,
                  output lock_value, input ready);
  modport sink   (input valid, input write_valid, input field_id, input char_pos,
                  input char_value, input sentence_start, input complete_mask,
                  input lock_value, output ready);
endinterface

interface nsfe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nsfe_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/nmea_sentence_field_extractor.sv
// ---------------------------------------------------------------------------
// NMEA sentence field extractor
// Decodes GGA/GSV/RMC sentences a byte at a time into field character words.
// ---------------------------------------------------------------------------
// Usage:
//  - rx carries one received byte per word. Every accepted byte yields exactly
//    one result word on res, in order.
//  - res gives the character write (write_valid, field id, position, value),
//    a start-of-sentence flag, the sticky completion mask and the lock state.
//  - cfg writes the two talker letters (index 0 first, 1 second); always
//    ready, to be used only while the block is idle.
//  - A byte's result is registered in the single result register and shows in
//    the cycle after. Throughput: one byte per cycle while res is read.
//  - Stall: while a result is held unread, rx.ready is low; a result taken in
//    the same cycle frees the register, so back-to-back flow is kept.
//  - Reset (rst, synchronous): parser idle, counters and completion mask
//    cleared, lock state zero, talker letters back to 'G','N'. The header
//    capture store is not cleared; it is always written before it is read.
// ---------------------------------------------------------------------------
`include "nmea_sentence_field_extractor_defines.svh"

module nmea_sentence_field_extractor (
  input  logic        clk,
  input  logic        rst,
  nsfe_in_if.sink     rx,
  nsfe_out_if.source  res,
  nsfe_cfg_if.sink    cfg
);

  // talker registers
  logic [7:0] talker_first;
  logic [7:0] talker_second;

  // parser state
  nsfe_pkg::mode_t mode, mode_next;
  nsfe_pkg::kind_t kind, kind_next;
  logic [7:0] comma_count, comma_count_next;
  logic [7:0] char_count, char_count_next;
  logic [7:0] header_chars [nsfe_pkg::HEADER_LEN];
  logic [2:0] done_bits, done_bits_next;
  logic [7:0] lock_state, lock_state_next;

  // decode
  logic           accept;
  logic [7:0]     b;
  logic           hdr_store;
  nsfe_pkg::kind_t hdr_kind;
  nsfe_pkg::field_t fld;
  logic           wr;

  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;
  assign rx.ready  = !res.valid || res.ready;
  assign cfg.ready = 1'b1;

  // header store fires for plain bytes inside the first five header slots
  assign hdr_store = (b != nsfe_pkg::CH_DOLLAR) && (b != nsfe_pkg::CH_COMMA) &&
                     (b != nsfe_pkg::CH_STAR) && (mode == nsfe_pkg::MODE_HDR) &&
                     (char_count < 8'(nsfe_pkg::HEADER_LEN));

  // match uses the stored four bytes plus the byte arriving now as the fifth
  always_comb begin
    hdr_kind = nsfe_pkg::KIND_NONE;
    if (header_chars[0] == talker_first && header_chars[1] == talker_second) begin
      if (header_chars[2] == nsfe_pkg::CH_G && header_chars[3] == nsfe_pkg::CH_G &&
          b == nsfe_pkg::CH_A) begin
        hdr_kind = nsfe_pkg::KIND_GGA;
      end else if (header_chars[2] == nsfe_pkg::CH_G && header_chars[3] == nsfe_pkg::CH_S &&
                   b == nsfe_pkg::CH_V) begin
        hdr_kind = nsfe_pkg::KIND_GSV;
      end else if (header_chars[2] == nsfe_pkg::CH_R && header_chars[3] == nsfe_pkg::CH_M &&
                   b == nsfe_pkg::CH_C) begin
        hdr_kind = nsfe_pkg::KIND_RMC;
      end
    end
  end

  assign fld = nsfe_pkg::field_lookup(kind, comma_count);

  always_comb begin
    mode_next        = mode;
    kind_next        = kind;
    comma_count_next = comma_count;
    char_count_next  = char_count;
    done_bits_next   = done_bits;
    lock_state_next  = lock_state;
    wr               = 1'b0;
    if (b == nsfe_pkg::CH_DOLLAR) begin
      kind_next       = nsfe_pkg::KIND_NONE;
      mode_next       = nsfe_pkg::MODE_HDR;
      char_count_next = 8'd0;
    end else if (b == nsfe_pkg::CH_COMMA) begin
      comma_count_next = comma_count + 8'd1;
      char_count_next  = 8'd0;
    end else if (b == nsfe_pkg::CH_STAR) begin
      case (kind)
        nsfe_pkg::KIND_GGA: done_bits_next = done_bits | nsfe_pkg::DONE_GGA;
        nsfe_pkg::KIND_GSV: done_bits_next = done_bits | nsfe_pkg::DONE_GSV;
        nsfe_pkg::KIND_RMC: done_bits_next = done_bits | nsfe_pkg::DONE_RMC;
        default:            done_bits_next = done_bits;
      endcase
      mode_next = nsfe_pkg::MODE_IDLE;
    end else begin
      // matched header: count restarts and then takes this byte, so ends at 1
      char_count_next = char_count + 8'd1;
      if (hdr_store && char_count == 8'(nsfe_pkg::HEADER_LEN - 1) &&
          hdr_kind != nsfe_pkg::KIND_NONE) begin
        kind_next        = hdr_kind;
        mode_next        = nsfe_pkg::MODE_DATA;
        comma_count_next = 8'd0;
        char_count_next  = 8'd1;
      end else if (mode == nsfe_pkg::MODE_DATA) begin
        if (kind == nsfe_pkg::KIND_RMC && comma_count == 8'd2) begin
          // RMC status: lock only, no write
          if (char_count == 8'd0) begin
            lock_state_next = (b == nsfe_pkg::CH_V) ? 8'd0 : 8'd1;
          end
        end else if (fld.hit && char_count < {4'd0, fld.limit}) begin
          wr = 1'b1;
          if (kind == nsfe_pkg::KIND_GGA && fld.id == nsfe_pkg::FLD_FIX) begin
            lock_state_next = b;
          end
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      talker_first  <= nsfe_pkg::TALKER_FIRST_RST;
      talker_second <= nsfe_pkg::TALKER_SECOND_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        nsfe_pkg::REG_TALKER_FIRST:  talker_first  <= cfg.data;
        nsfe_pkg::REG_TALKER_SECOND: talker_second <= cfg.data;
        default: ;
      endcase
    end
  end

  // header capture store, no reset
  always_ff @(posedge clk) begin
    if (accept && hdr_store) begin
      header_chars[char_count[nsfe_pkg::HDR_IDX_W-1:0]] <= b;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= nsfe_pkg::MODE_IDLE;
      kind        <= nsfe_pkg::KIND_NONE;
      comma_count <= 8'd0;
      char_count  <= 8'd0;
      done_bits   <= 3'd0;
      lock_state  <= 8'd0;
    end else if (accept) begin
      mode        <= mode_next;
      kind        <= kind_next;
      comma_count <= comma_count_next;
      char_count  <= char_count_next;
      done_bits   <= done_bits_next;
      lock_state  <= lock_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.write_valid    <= wr;
      res.field_id       <= wr ? fld.id : 4'd0;
      res.char_pos       <= wr ? char_count[3:0] : 4'd0;
      res.char_value     <= wr ? b : 8'd0;
      res.sentence_start <= (b == nsfe_pkg::CH_DOLLAR);
      res.complete_mask  <= done_bits_next;
      res.lock_value     <= lock_state_next;
    end
  end

  // checks
  `NSFE_ASSERT(a_write_in_data, clk, rst, res.valid && res.write_valid |-> mode == nsfe_pkg::MODE_DATA, "field write outside data mode")
  `NSFE_ASSERT(a_done_sticky, clk, rst, 1'b1 |=> ((done_bits & $past(done_bits)) == $past(done_bits)), "completion bit lost")
  `NSFE_ASSERT(a_stall_blocks_rx, clk, rst, res.valid && !res.ready |-> !rx.ready, "byte taken while result stalled")
  `NSFE_ASSERT_NORST(a_reset_clears, clk, rst |=> (mode == nsfe_pkg::MODE_IDLE && done_bits == 3'd0 && !res.valid), "reset did not clear parser")

endmodule

### test/nmea_sentence_field_extractor_test.sv
// ---------------------------------------------------------------------------
// NMEA sentence field extractor testbench
// Streams NMEA text into the extractor: a short directed burst, then random
// GGA/GSV/RMC sentences mixed with noise, broken sentences and counter-wrap
// runs, over several talker settings and idling profiles. A scoreboard
// tracks the parser state and checks every result word field by field.
// ---------------------------------------------------------------------------
module nmea_sentence_field_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 300;

  // long runs that push the 8-bit counters round
  typedef enum int {
    RUN_COMMA_WRAP,
    RUN_FIELD_WRAP,
    RUN_HEADER_WRAP
  } long_run_t;

  // one result word as the block reports it
  typedef struct packed {
    logic       write_valid;
    logic [3:0] field_id;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       sentence_start;
    logic [2:0] complete_mask;
    logic [7:0] lock_value;
  } field_word_t;

  // -------------------------------------------------------------------------
  // Parser scoreboard: own copy of the parser state, one expected word per
  // accepted byte, checked in order against the result channel.
  // -------------------------------------------------------------------------
  class field_word_board;
    logic [7:0]      talker_a = nsfe_pkg::TALKER_FIRST_RST;
    logic [7:0]      talker_b = nsfe_pkg::TALKER_SECOND_RST;
    nsfe_pkg::mode_t mode     = nsfe_pkg::MODE_IDLE;
    nsfe_pkg::kind_t kind     = nsfe_pkg::KIND_NONE;
    logic [7:0]      commas   = '0;
    logic [7:0]      chars    = '0;
    logic [7:0]      hdr [nsfe_pkg::HEADER_LEN];
    logic [2:0]      done     = '0;
    logic [7:0]      lock     = '0;
    field_word_t     expected_words[$];
    int              errors   = 0;

    function void write_reg(logic [nsfe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        nsfe_pkg::REG_TALKER_FIRST:  talker_a = data;
        nsfe_pkg::REG_TALKER_SECOND: talker_b = data;
        default: ;
      endcase
    endfunction

    function nsfe_pkg::kind_t header_kind();
      if (hdr[0] != talker_a || hdr[1] != talker_b) return nsfe_pkg::KIND_NONE;
      if ({hdr[2], hdr[3], hdr[4]} == {nsfe_pkg::CH_G, nsfe_pkg::CH_G, nsfe_pkg::CH_A})
        return nsfe_pkg::KIND_GGA;
      if ({hdr[2], hdr[3], hdr[4]} == {nsfe_pkg::CH_G, nsfe_pkg::CH_S, nsfe_pkg::CH_V})
        return nsfe_pkg::KIND_GSV;
      if ({hdr[2], hdr[3], hdr[4]} == {nsfe_pkg::CH_R, nsfe_pkg::CH_M, nsfe_pkg::CH_C})
        return nsfe_pkg::KIND_RMC;
      return nsfe_pkg::KIND_NONE;
    endfunction

    // which field (and its length limit) the current comma selects
    function bit field_for(output logic [3:0] id, output logic [3:0] limit);
      id    = '0;
      limit = '0;
      case (kind)
        nsfe_pkg::KIND_GGA: begin
          case (commas)
            8'd2:    {id, limit} = {nsfe_pkg::FLD_LAT,    4'd9};
            8'd3:    {id, limit} = {nsfe_pkg::FLD_LATDIR, 4'd1};
            8'd4:    {id, limit} = {nsfe_pkg::FLD_LON,    4'd10};
            8'd5:    {id, limit} = {nsfe_pkg::FLD_LONDIR, 4'd1};
            8'd6:    {id, limit} = {nsfe_pkg::FLD_FIX,    4'd1};
            8'd7:    {id, limit} = {nsfe_pkg::FLD_USED,   4'd2};
            8'd9:    {id, limit} = {nsfe_pkg::FLD_ALT,    4'd6};
            default: return 1'b0;
          endcase
        end
        nsfe_pkg::KIND_GSV: begin
          if (commas != 8'd3) return 1'b0;
          {id, limit} = {nsfe_pkg::FLD_TOTAL, 4'd2};
        end
        nsfe_pkg::KIND_RMC: begin
          case (commas)
            8'd1:    {id, limit} = {nsfe_pkg::FLD_TIME,   4'd6};
            8'd4:    {id, limit} = {nsfe_pkg::FLD_LATDIR, 4'd1};
            8'd6:    {id, limit} = {nsfe_pkg::FLD_LONDIR, 4'd1};
            8'd7:    {id, limit} = {nsfe_pkg::FLD_SPEED,  4'd5};
            8'd8:    {id, limit} = {nsfe_pkg::FLD_COURSE, 4'd5};
            8'd9:    {id, limit} = {nsfe_pkg::FLD_DATE,   4'd6};
            default: return 1'b0;
          endcase
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void predict_byte(logic [7:0] b);
      field_word_t     w;
      nsfe_pkg::kind_t k;
      logic [3:0]      id;
      logic [3:0]      limit;
      w = '0;
      if (b == nsfe_pkg::CH_DOLLAR) begin
        kind             = nsfe_pkg::KIND_NONE;
        mode             = nsfe_pkg::MODE_HDR;
        chars            = '0;
        w.sentence_start = 1'b1;
      end else if (b == nsfe_pkg::CH_COMMA) begin
        // commas count in every mode, header included
        commas = commas + 8'd1;
        chars  = '0;
      end else if (b == nsfe_pkg::CH_STAR) begin
        // kind is not cleared here, so a stray star repeats the last kind
        case (kind)
          nsfe_pkg::KIND_GGA: done = done | nsfe_pkg::DONE_GGA;
          nsfe_pkg::KIND_GSV: done = done | nsfe_pkg::DONE_GSV;
          nsfe_pkg::KIND_RMC: done = done | nsfe_pkg::DONE_RMC;
          default: ;
        endcase
        mode = nsfe_pkg::MODE_IDLE;
      end else begin
        if (mode == nsfe_pkg::MODE_HDR) begin
          // only the first five header characters are kept
          if (chars < 8'(nsfe_pkg::HEADER_LEN)) begin
            hdr[chars[nsfe_pkg::HDR_IDX_W-1:0]] = b;
            if (chars == 8'(nsfe_pkg::HEADER_LEN - 1)) begin
              k = header_kind();
              if (k != nsfe_pkg::KIND_NONE) begin
                kind   = k;
                mode   = nsfe_pkg::MODE_DATA;
                commas = '0;
                chars  = '0;
              end
            end
          end
        end else if (mode == nsfe_pkg::MODE_DATA) begin
          if (kind == nsfe_pkg::KIND_RMC && commas == 8'd2) begin
            // RMC status: lock only, never stored as a character
            if (chars == 8'd0) lock = (b == nsfe_pkg::CH_V) ? 8'd0 : 8'd1;
          end else if (field_for(id, limit) && chars < {4'd0, limit}) begin
            w.write_valid = 1'b1;
            w.field_id    = id;
            w.char_pos    = chars[3:0];
            w.char_value  = b;
            if (kind == nsfe_pkg::KIND_GGA && id == nsfe_pkg::FLD_FIX) lock = b;
          end
        end
        chars = chars + 8'd1;
      end
      w.complete_mask = done;
      w.lock_value    = lock;
      expected_words.push_back(w);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(field_word_t got);
      field_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t ns: result word %0h with none expected", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("write_valid",    8'(want.write_valid),    8'(got.write_valid));
      compare("field_id",       8'(want.field_id),       8'(got.field_id));
      compare("char_pos",       8'(want.char_pos),       8'(got.char_pos));
      compare("char_value",     want.char_value,         got.char_value);
      compare("sentence_start", 8'(want.sentence_start), 8'(got.sentence_start));
      compare("complete_mask",  8'(want.complete_mask),  8'(got.complete_mask));
      compare("lock_value",     want.lock_value,         got.lock_value);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  nsfe_in_if  rx_ch ();
  nsfe_out_if res_ch ();
  nsfe_cfg_if cfg_ch ();

  nmea_sentence_field_extractor dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  field_word_board board;
  logic [7:0]      stream[$];   // bytes waiting to be sent
  logic [7:0]      talk_a;      // talker letters the generator aims at
  logic [7:0]      talk_b;
  int              gap_pct;     // sender idle chance per word, percent
  int              stall_pct;   // receiver stall chance per cycle, percent

  // receiver: ready changes on the falling edge only
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitors: everything is sampled on the rising edge, before the
  // block's own registers move
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
      if (rx_ch.valid && rx_ch.ready) board.predict_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        board.check_word({res_ch.write_valid, res_ch.field_id, res_ch.char_pos,
                          res_ch.char_value, res_ch.sentence_start,
                          res_ch.complete_mask, res_ch.lock_value});
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus builders
  // -------------------------------------------------------------------------
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  // mostly digits, some dots and letters, now and then any byte at all
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h30 + 8'($urandom_range(9));
    if (r < 80) return 8'h2E;
    if (r < 92) return 8'h41 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // one sentence: mostly well formed with random content; some noise,
  // corrupted headers, over-long headers and missing terminators
  task automatic push_sentence();
    int    nfields;
    int    len;
    int    sel;
    string name;
    string hex_digits;
    hex_digits = "0123456789ABCDEF";
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(20, 1)) stream.push_back(8'($urandom_range(255)));
      return;
    end
    stream.push_back(nsfe_pkg::CH_DOLLAR);
    if ($urandom_range(9) == 0) begin
      stream.push_back(8'($urandom_range(255)));
      stream.push_back(8'($urandom_range(255)));
    end else begin
      stream.push_back(talk_a);
      stream.push_back(talk_b);
    end
    sel  = $urandom_range(2);
    name = (sel == 0) ? "GGA" : (sel == 1) ? "GSV" : "RMC";
    push_text(name);
    if ($urandom_range(11) == 0) stream[stream.size() - 1 - $urandom_range(4)] = pick_char();
    if ($urandom_range(19) == 0) repeat ($urandom_range(4, 1)) stream.push_back(pick_char());
    nfields = $urandom_range(14);
    for (int f = 1; f <= nfields; f++) begin
      stream.push_back(nsfe_pkg::CH_COMMA);
      len = $urandom_range(11);
      for (int c = 0; c < len; c++) begin
        if (sel == 2 && f == 2 && c == 0)
          stream.push_back($urandom_range(1) ? nsfe_pkg::CH_V : nsfe_pkg::CH_A);
        else if (sel == 0 && f == 6 && c == 0)
          stream.push_back(8'h30 + 8'($urandom_range(2)));
        else
          stream.push_back(pick_char());
      end
    end
    if ($urandom_range(99) < 88) begin
      stream.push_back(nsfe_pkg::CH_STAR);
      push_text(hex_digits.substr($urandom_range(15), $urandom_range(15)));
      stream.push_back(8'h0D);
      stream.push_back(8'h0A);
    end
  endtask

  task automatic push_long_run(long_run_t run);
    stream.push_back(nsfe_pkg::CH_DOLLAR);
    case (run)
      RUN_COMMA_WRAP: begin
        // 258 commas bring the field counter back round to latitude
        stream.push_back(talk_a);
        stream.push_back(talk_b);
        push_text("GGA");
        repeat (258) stream.push_back(nsfe_pkg::CH_COMMA);
        push_text("4916.4");
      end
      RUN_FIELD_WRAP: begin
        // char counter wraps inside the time field, so writes start again
        stream.push_back(talk_a);
        stream.push_back(talk_b);
        push_text("RMC");
        stream.push_back(nsfe_pkg::CH_COMMA);
        repeat (262) stream.push_back(8'h30 + 8'($urandom_range(9)));
      end
      default: begin
        // header junk long enough for the char counter to wrap, then a
        // header that is captured afresh
        repeat (256) stream.push_back(8'h41 + 8'($urandom_range(25)));
        stream.push_back(talk_a);
        stream.push_back(talk_b);
        push_text("GSV,,,07");
      end
    endcase
    stream.push_back(nsfe_pkg::CH_STAR);
  endtask

  // -------------------------------------------------------------------------
  // Drivers: all inputs change on the falling edge
  // -------------------------------------------------------------------------
  task automatic send_stream();
    while (stream.size() != 0) begin
      while ($urandom_range(99) < gap_pct) begin
        rx_ch.valid <= 1'b0;
        @(negedge clk);
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= stream.pop_front();
      @(posedge clk);
      while (!rx_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    rx_ch.valid <= 1'b0;
  endtask

  // every byte gives one word, so empty means the block is idle
  task automatic wait_drained();
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(logic [nsfe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_talker(logic [7:0] a, logic [7:0] b);
    cfg_write(nsfe_pkg::REG_TALKER_FIRST, a);
    cfg_write(nsfe_pkg::REG_TALKER_SECOND, b);
    talk_a = a;
    talk_b = b;
  endtask

  // -------------------------------------------------------------------------
  // Run
  // -------------------------------------------------------------------------
  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    board         = new;
    talk_a        = nsfe_pkg::TALKER_FIRST_RST;
    talk_b        = nsfe_pkg::TALKER_SECOND_RST;
    gap_pct       = 13;
    stall_pct     = 45;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: byte extremes, stray star and comma while idle, a GGA with
    // a fix character, an RMC with a void status; reset talker letters
    stream.push_back(8'h00);
    stream.push_back(8'hFF);
    push_text("*,$GNGGA,,,,,,7*$GNRMC,,V*");
    send_stream();

    for (int ph = 0; ph < PHASES; ph++) begin
      // sender 13 / receiver 45, then swapped, then no idling at all
      gap_pct   = (ph < 2) ? 13 : (ph < 4) ? 45 : 0;
      stall_pct = (ph < 2) ? 45 : (ph < 4) ? 13 : 0;
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1:       set_talker(nsfe_pkg::CH_G, 8'h50);
          2:       set_talker(8'h00, 8'hFF);
          3:       set_talker(8'hFF, 8'h00);
          4:       set_talker(8'($urandom_range(255)), 8'($urandom_range(255)));
          default: set_talker(nsfe_pkg::TALKER_FIRST_RST, nsfe_pkg::TALKER_SECOND_RST);
        endcase
      end
      push_long_run(long_run_t'(ph % 3));
      while (stream.size() < PHASE_BYTES) push_sentence();
      send_stream();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("%0t ns: timeout, %0d words outstanding", $time, board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### nmea_sentence_field_extractor.f
+incdir+rtl/core
rtl/core/nsfe_pkg.sv
rtl/core/nsfe_if.sv
rtl/core/nmea_sentence_field_extractor.sv
test/nmea_sentence_field_extractor_test.sv
